// ===== hw/rtl/elfe_pkg.sv =====
`default_nettype none

package elfe_pkg;

    // Field widths.
    localparam int unsigned BYTE_W   = 8;
    localparam int unsigned LEN_W    = 16;
    localparam int unsigned CFG_IDX_W = 3;

    // Most line bytes one transaction can produce.
    localparam int unsigned MAX_RESULTS = 6;
    localparam int unsigned RES_IDX_W   = 3;

    // Input command codes.
    localparam logic CMD_START = 1'b0;
    localparam logic CMD_DATA  = 1'b1;

    // Configuration register indexes.
    localparam logic [CFG_IDX_W-1:0] REG_FRAME_LENGTH      = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_START_MARKER      = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_END_MARKER        = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_ESCAPE_MARKER     = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_START_SUBSTITUTE  = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_END_SUBSTITUTE    = 3'd5;
    localparam logic [CFG_IDX_W-1:0] REG_ESCAPE_SUBSTITUTE = 3'd6;

    // Reset values of the marker registers.
    localparam logic [BYTE_W-1:0] RST_START_MARKER      = 8'd126;
    localparam logic [BYTE_W-1:0] RST_END_MARKER        = 8'd127;
    localparam logic [BYTE_W-1:0] RST_ESCAPE_MARKER     = 8'd125;
    localparam logic [BYTE_W-1:0] RST_START_SUBSTITUTE  = 8'd94;
    localparam logic [BYTE_W-1:0] RST_END_SUBSTITUTE    = 8'd95;
    localparam logic [BYTE_W-1:0] RST_ESCAPE_SUBSTITUTE = 8'd93;

    typedef logic [BYTE_W-1:0] byte_t;

    // Marker and substitute settings as one group.
    typedef struct packed {
        byte_t start_marker;
        byte_t end_marker;
        byte_t escape_marker;
        byte_t start_substitute;
        byte_t end_substitute;
        byte_t escape_substitute;
    } marker_cfg_t;

    // One or two line bytes for a stuffed payload byte.
    typedef struct packed {
        byte_t first;
        byte_t second;
        logic  two;
    } escaped_t;

    // Stuff one byte; the start marker is tested first, then end, then escape.
    function automatic escaped_t elfe_escape(input byte_t b, input marker_cfg_t m);
        escaped_t e;
        e.first  = m.escape_marker;
        e.second = '0;
        e.two    = 1'b1;
        if (b == m.start_marker) begin
            e.second = m.start_substitute;
        end else if (b == m.end_marker) begin
            e.second = m.end_substitute;
        end else if (b == m.escape_marker) begin
            e.second = m.escape_substitute;
        end else begin
            e.first = b;
            e.two   = 1'b0;
        end
        return e;
    endfunction

endpackage

`default_nettype wire

// ===== hw/rtl/elfe_if.sv =====
`default_nettype none

// Input channel: one command per transaction.
interface elfe_in_if
    import elfe_pkg::*;
();
    logic  valid;
    logic  ready;
    logic  command;
    byte_t data_byte;

    modport source (output valid, output command, output data_byte, input ready);
    modport sink   (input valid, input command, input data_byte, output ready);
endinterface

// Output channel: one line byte per transaction.
interface elfe_out_if
    import elfe_pkg::*;
();
    logic  valid;
    logic  ready;
    byte_t out_byte;
    logic  status;
    logic  frame_end;
    logic  is_last;

    modport source (output valid, output out_byte, output status, output frame_end,
                    output is_last, input ready);
    modport sink   (input valid, input out_byte, input status, input frame_end,
                    input is_last, output ready);
endinterface

`default_nettype wire

// ===== hw/rtl/escaped_length_frame_encoder_top.sv =====
// The first line byte of a command passes through the input register and then the burst register,
// which loads once the output is free, before it is valid on out_ch.
// Throughput: one line byte per cycle while the output is ready; line bytes per command:
// start 3 to 6, payload byte 1 to 3, rejected byte 1.
// The input register accepts the next command while the previous burst still drains.
// Reset clears the frame state, the burst and input registers, and loads the register defaults.
`default_nettype none

module escaped_length_frame_encoder_top
    import elfe_pkg::*;
(
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire logic                 cfg_we,
    input  wire logic [CFG_IDX_W-1:0] cfg_index,
    input  wire logic [LEN_W-1:0]     cfg_wdata,
    elfe_in_if.sink                   in_ch,
    elfe_out_if.source                out_ch
);

    typedef enum logic [1:0] {
        PH_IDLE,
        PH_DATA
    } phase_t;

    // Configuration registers.
    logic [LEN_W-1:0] frame_length_reg;
    marker_cfg_t      markers_reg;

    // Input register.
    logic  a_valid_reg;
    logic  a_cmd_reg;
    byte_t a_data_reg;

    // Frame state.
    phase_t           phase_reg, phase_next;
    logic [LEN_W-1:0] bytes_sent_reg, bytes_sent_next;
    logic [LEN_W-1:0] active_length_reg, active_length_next;

    // Burst register: the line bytes of one command, drained one per cycle while the output is ready.
    logic                 b_valid_reg;
    byte_t                b_bytes_reg [MAX_RESULTS];
    logic [RES_IDX_W-1:0] b_last_reg;
    logic [RES_IDX_W-1:0] b_idx_reg;
    logic                 b_end_reg;
    logic                 b_status_reg;

    byte_t                b_bytes_next [MAX_RESULTS];
    logic [RES_IDX_W-1:0] cnt;
    logic                 b_end_next;
    logic                 b_status_next;
    escaped_t             e;

    logic b_at_last;
    logic out_fire;
    logic a_move;
    logic in_fire;

    assign b_at_last = (b_idx_reg == b_last_reg);
    assign out_fire  = b_valid_reg && out_ch.ready;
    assign a_move    = a_valid_reg && (!b_valid_reg || (b_at_last && out_ch.ready));
    assign in_fire   = in_ch.valid && in_ch.ready;

    assign in_ch.ready      = !a_valid_reg || a_move;
    assign out_ch.valid     = b_valid_reg;
    assign out_ch.out_byte  = b_bytes_reg[b_idx_reg];
    assign out_ch.status    = b_status_reg;
    assign out_ch.frame_end = b_end_reg && b_at_last;
    assign out_ch.is_last   = b_at_last;

    // Configuration writes.
    always_ff @(posedge clk or negedge rst_n) begin
        if (!rst_n) begin
            frame_length_reg               <= '0;
            markers_reg.start_marker       <= RST_START_MARKER;
            markers_reg.end_marker         <= RST_END_MARKER;
            markers_reg.escape_marker      <= RST_ESCAPE_MARKER;
            markers_reg.start_substitute   <= RST_START_SUBSTITUTE;
            markers_reg.end_substitute     <= RST_END_SUBSTITUTE;
            markers_reg.escape_substitute  <= RST_ESCAPE_SUBSTITUTE;
        end else if (cfg_we) begin
            unique case (cfg_index)
                REG_FRAME_LENGTH:      frame_length_reg <= cfg_wdata;
                REG_START_MARKER:      markers_reg.start_marker <= cfg_wdata[BYTE_W-1:0];
                REG_END_MARKER:        markers_reg.end_marker <= cfg_wdata[BYTE_W-1:0];
                REG_ESCAPE_MARKER:     markers_reg.escape_marker <= cfg_wdata[BYTE_W-1:0];
                REG_START_SUBSTITUTE:  markers_reg.start_substitute <= cfg_wdata[BYTE_W-1:0];
                REG_END_SUBSTITUTE:    markers_reg.end_substitute <= cfg_wdata[BYTE_W-1:0];
                REG_ESCAPE_SUBSTITUTE: markers_reg.escape_substitute <= cfg_wdata[BYTE_W-1:0];
                default: ;
            endcase
        end
    end

    // Build the burst for the registered command and the next frame state.
    always_comb begin
        for (int i = 0; i < MAX_RESULTS; i++) begin
            b_bytes_next[i] = '0;
        end
        cnt                = '0;
        b_end_next         = 1'b0;
        b_status_next      = 1'b0;
        phase_next         = phase_reg;
        bytes_sent_next    = bytes_sent_reg;
        active_length_next = active_length_reg;
        e                  = '0;

        if (a_cmd_reg == CMD_START) begin
            active_length_next = frame_length_reg;
            bytes_sent_next    = '0;
            b_bytes_next[0]    = markers_reg.start_marker;
            cnt                = RES_IDX_W'(1);
            // Length low byte.
            e = elfe_escape(frame_length_reg[BYTE_W-1:0], markers_reg);
            b_bytes_next[cnt] = e.first;
            cnt = cnt + RES_IDX_W'(1);
            if (e.two) begin
                b_bytes_next[cnt] = e.second;
                cnt = cnt + RES_IDX_W'(1);
            end
            // Length high byte.
            e = elfe_escape(frame_length_reg[LEN_W-1:BYTE_W], markers_reg);
            b_bytes_next[cnt] = e.first;
            cnt = cnt + RES_IDX_W'(1);
            if (e.two) begin
                b_bytes_next[cnt] = e.second;
                cnt = cnt + RES_IDX_W'(1);
            end
            // An empty frame closes at once.
            if (frame_length_reg == '0) begin
                b_bytes_next[cnt] = markers_reg.end_marker;
                b_end_next        = 1'b1;
                cnt = cnt + RES_IDX_W'(1);
                phase_next        = PH_IDLE;
            end else begin
                phase_next = PH_DATA;
            end
        end else if ((phase_reg == PH_DATA) && (bytes_sent_reg < active_length_reg)) begin
            e = elfe_escape(a_data_reg, markers_reg);
            b_bytes_next[0] = e.first;
            cnt = RES_IDX_W'(1);
            if (e.two) begin
                b_bytes_next[cnt] = e.second;
                cnt = cnt + RES_IDX_W'(1);
            end
            bytes_sent_next = bytes_sent_reg + LEN_W'(1);
            // The last payload byte closes the frame.
            if (bytes_sent_next == active_length_reg) begin
                b_bytes_next[cnt] = markers_reg.end_marker;
                b_end_next        = 1'b1;
                cnt = cnt + RES_IDX_W'(1);
                phase_next        = PH_IDLE;
            end
        end else begin
            // Data outside an open frame or past its length is rejected.
            b_status_next = 1'b1;
            cnt           = RES_IDX_W'(1);
        end
    end

    // Input register control, frame state and burst control.
    always_ff @(posedge clk or negedge rst_n) begin
        if (!rst_n) begin
            a_valid_reg       <= 1'b0;
            phase_reg         <= PH_IDLE;
            bytes_sent_reg    <= '0;
            active_length_reg <= '0;
            b_valid_reg       <= 1'b0;
            b_idx_reg         <= '0;
            b_last_reg        <= '0;
            b_end_reg         <= 1'b0;
            b_status_reg      <= 1'b0;
        end else begin
            if (in_fire) begin
                a_valid_reg <= 1'b1;
            end else if (a_move) begin
                a_valid_reg <= 1'b0;
            end

            if (a_move) begin
                phase_reg         <= phase_next;
                bytes_sent_reg    <= bytes_sent_next;
                active_length_reg <= active_length_next;
                b_valid_reg       <= 1'b1;
                b_idx_reg         <= '0;
                b_last_reg        <= cnt - RES_IDX_W'(1);
                b_end_reg         <= b_end_next;
                b_status_reg      <= b_status_next;
            end else if (out_fire) begin
                if (b_at_last) begin
                    b_valid_reg <= 1'b0;
                end else begin
                    b_idx_reg <= b_idx_reg + RES_IDX_W'(1);
                end
            end
        end
    end

    // Payload registers.
    always_ff @(posedge clk) begin
        if (in_fire) begin
            a_cmd_reg  <= in_ch.command;
            a_data_reg <= in_ch.data_byte;
        end
        if (a_move) begin
            b_bytes_reg <= b_bytes_next;
        end
    end

endmodule

`default_nettype wire

// ===== test/line_byte_check.sv =====
`timescale 1ns / 1ps

// Watches both channels of the frame encoder, predicts the stuffed line bytes
// for every accepted command and compares them with what comes out.
module line_byte_check
    import elfe_pkg::*;
(
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire logic                 cfg_we,
    input  wire logic [CFG_IDX_W-1:0] cfg_index,
    input  wire logic [LEN_W-1:0]     cfg_wdata,
    elfe_in_if                        in_ch,
    elfe_out_if                       out_ch,
    output int                        mismatches,
    output int                        bytes_due
);

    typedef enum logic [1:0] {FRAME_IDLE, FRAME_OPEN} frame_phase_t;

    typedef struct packed {
        byte_t out_byte;
        logic  status;
        logic  frame_end;
        logic  is_last;
    } line_byte_t;

    // Shadow registers and frame state.
    marker_cfg_t      markers;
    logic [LEN_W-1:0] next_length;
    logic [LEN_W-1:0] open_length;
    logic [LEN_W-1:0] payload_taken;
    frame_phase_t     frame_phase;

    // Line bytes of the command being predicted, and all bytes still owed.
    line_byte_t       burst[$];
    line_byte_t       expected_bytes[$];
    int               fail_count = 0;

    function automatic void emit_byte(input byte_t b, input logic rejected, input logic closing);
        line_byte_t lb;
        lb.out_byte  = b;
        lb.status    = rejected;
        lb.frame_end = closing;
        lb.is_last   = 1'b0;
        burst.push_back(lb);
    endfunction

    // The start marker is matched first, then the end marker, then the escape.
    function automatic void emit_stuffed(input byte_t b);
        if (b == markers.start_marker) begin
            emit_byte(markers.escape_marker, 1'b0, 1'b0);
            emit_byte(markers.start_substitute, 1'b0, 1'b0);
        end else if (b == markers.end_marker) begin
            emit_byte(markers.escape_marker, 1'b0, 1'b0);
            emit_byte(markers.end_substitute, 1'b0, 1'b0);
        end else if (b == markers.escape_marker) begin
            emit_byte(markers.escape_marker, 1'b0, 1'b0);
            emit_byte(markers.escape_substitute, 1'b0, 1'b0);
        end else begin
            emit_byte(b, 1'b0, 1'b0);
        end
    endfunction

    // Work out the line bytes one command produces and queue them.
    function automatic void predict_line_bytes(input logic cmd, input byte_t data);
        line_byte_t tail;
        burst.delete();
        if (cmd == CMD_START) begin
            // A start always opens a fresh frame, abandoning any open one.
            open_length   = next_length;
            payload_taken = '0;
            emit_byte(markers.start_marker, 1'b0, 1'b0);
            emit_stuffed(open_length[BYTE_W-1:0]);
            emit_stuffed(open_length[LEN_W-1:BYTE_W]);
            if (open_length == '0) begin
                emit_byte(markers.end_marker, 1'b0, 1'b1);
                frame_phase = FRAME_IDLE;
            end else begin
                frame_phase = FRAME_OPEN;
            end
        end else if (frame_phase == FRAME_OPEN && payload_taken < open_length) begin
            emit_stuffed(data);
            payload_taken = payload_taken + 1'b1;
            if (payload_taken >= open_length) begin
                emit_byte(markers.end_marker, 1'b0, 1'b1);
                frame_phase = FRAME_IDLE;
            end
        end else begin
            // Payload outside a frame or past its length is refused.
            emit_byte('0, 1'b1, 1'b0);
        end
        tail = burst.pop_back();
        tail.is_last = 1'b1;
        burst.push_back(tail);
        foreach (burst[i]) begin
            expected_bytes.push_back(burst[i]);
        end
    endfunction

    function automatic void apply_register(input logic [CFG_IDX_W-1:0] idx,
                                           input logic [LEN_W-1:0] value);
        case (idx)
            REG_FRAME_LENGTH:      next_length                = value;
            REG_START_MARKER:      markers.start_marker      = value[BYTE_W-1:0];
            REG_END_MARKER:        markers.end_marker        = value[BYTE_W-1:0];
            REG_ESCAPE_MARKER:     markers.escape_marker     = value[BYTE_W-1:0];
            REG_START_SUBSTITUTE:  markers.start_substitute  = value[BYTE_W-1:0];
            REG_END_SUBSTITUTE:    markers.end_substitute    = value[BYTE_W-1:0];
            REG_ESCAPE_SUBSTITUTE: markers.escape_substitute = value[BYTE_W-1:0];
            default: ;
        endcase
    endfunction

    task automatic report_mismatch(input string what);
        $display("MISMATCH at %0t: %s", $time, what);
        fail_count++;
    endtask

    // Compare one received line byte with the oldest one owed.
    task automatic check_line_byte(input line_byte_t got);
        line_byte_t want;
        if (expected_bytes.size() == 0) begin
            report_mismatch($sformatf("line byte %02h with nothing outstanding", got.out_byte));
        end else begin
            want = expected_bytes.pop_front();
            if (got.out_byte !== want.out_byte) begin
                report_mismatch($sformatf("out_byte %02h, want %02h", got.out_byte,
                                          want.out_byte));
            end
            if (got.status !== want.status) begin
                report_mismatch($sformatf("status %b, want %b", got.status, want.status));
            end
            if (got.frame_end !== want.frame_end) begin
                report_mismatch($sformatf("frame_end %b, want %b", got.frame_end,
                                          want.frame_end));
            end
            if (got.is_last !== want.is_last) begin
                report_mismatch($sformatf("is_last %b, want %b", got.is_last, want.is_last));
            end
        end
    endtask

    // Sample every transaction at the clock edge that completes it.
    always @(posedge clk or negedge rst_n) begin : monitor
        line_byte_t seen;
        if (!rst_n) begin
            markers.start_marker      = RST_START_MARKER;
            markers.end_marker        = RST_END_MARKER;
            markers.escape_marker     = RST_ESCAPE_MARKER;
            markers.start_substitute  = RST_START_SUBSTITUTE;
            markers.end_substitute    = RST_END_SUBSTITUTE;
            markers.escape_substitute = RST_ESCAPE_SUBSTITUTE;
            next_length   = '0;
            open_length   = '0;
            payload_taken = '0;
            frame_phase   = FRAME_IDLE;
            expected_bytes.delete();
            bytes_due  <= 0;
            mismatches <= fail_count;
        end else begin
            if (out_ch.valid && out_ch.ready) begin
                seen.out_byte  = out_ch.out_byte;
                seen.status    = out_ch.status;
                seen.frame_end = out_ch.frame_end;
                seen.is_last   = out_ch.is_last;
                check_line_byte(seen);
            end
            if (cfg_we) begin
                apply_register(cfg_index, cfg_wdata);
            end
            if (in_ch.valid && in_ch.ready) begin
                predict_line_bytes(in_ch.command, in_ch.data_byte);
            end
            bytes_due  <= expected_bytes.size();
            mismatches <= fail_count;
        end
    end

endmodule

// ===== test/tb.sv =====
`timescale 1ns / 1ps

module tb;
    import elfe_pkg::*;

    localparam int RESET_CYCLES = 7;
    localparam int LONG_HOLD    = 300;
    localparam int QUIET_LIMIT  = 2000;
    localparam int DRAIN_CYCLES = 16;
    localparam int PHASE_ITEMS  = 20;

    logic                 clk = 1'b0;
    logic                 rst_n;
    logic                 cfg_we;
    logic [CFG_IDX_W-1:0] cfg_index;
    logic [LEN_W-1:0]     cfg_wdata;

    int    mismatch_count;
    int    bytes_outstanding;
    int    send_idle_pct;
    int    recv_stall_pct;
    int    hold_requests;
    int    items_sent;
    byte_t cur_start;
    byte_t cur_end;
    byte_t cur_escape;

    elfe_in_if  in_ch ();
    elfe_out_if out_ch ();

    escaped_length_frame_encoder_top dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata),
        .in_ch     (in_ch),
        .out_ch    (out_ch)
    );

    line_byte_check line_check (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg_we     (cfg_we),
        .cfg_index  (cfg_index),
        .cfg_wdata  (cfg_wdata),
        .in_ch      (in_ch),
        .out_ch     (out_ch),
        .mismatches (mismatch_count),
        .bytes_due  (bytes_outstanding)
    );

    always
    begin
        #2 clk = 1'b1;
        #2 clk = 1'b0;
    end

    // Receiver: random stalls, plus a long hold-off whenever one is requested.
    initial
    begin
        int hold_left;
        int holds_served;
        hold_left    = 0;
        holds_served = 0;
        out_ch.ready = 1'b0;
        forever
        begin
            @(posedge clk);
            if (hold_requests != holds_served)
            begin
                holds_served = hold_requests;
                hold_left    = LONG_HOLD;
            end
            if (hold_left > 0)
            begin
                hold_left--;
                out_ch.ready <= 1'b0;
            end
            else
            begin
                out_ch.ready <= ($urandom_range(99) >= recv_stall_pct);
            end
        end
    end

    // Watchdog: give up when no transaction completes for too long.
    initial
    begin
        int quiet_cycles;
        quiet_cycles = 0;
        forever
        begin
            @(posedge clk);
            if (!rst_n || (in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready))
            begin
                quiet_cycles = 0;
            end
            else
            begin
                quiet_cycles++;
            end
            if (quiet_cycles >= QUIET_LIMIT)
            begin
                $display("Regression FAIL");
                $finish;
            end
        end
    end

    // Offer one command after a random gap and hold it until it is taken.
    task automatic send_command(input logic cmd, input byte_t data);
        int gap;
        gap = 0;
        while (gap < 20 && $urandom_range(99) < send_idle_pct)
        begin
            gap++;
        end
        if (gap > 0)
        begin
            in_ch.valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_ch.valid     <= 1'b1;
        in_ch.command   <= cmd;
        in_ch.data_byte <= data;
        do @(posedge clk); while (!in_ch.ready);
        items_sent++;
    endtask

    // Stop offering and wait until every owed line byte has been delivered.
    task automatic settle();
        in_ch.valid <= 1'b0;
        do @(posedge clk); while (bytes_outstanding != 0);
    endtask

    // The caller lowers the write enable after the last write of a group.
    task automatic write_register(input logic [CFG_IDX_W-1:0] idx, input logic [LEN_W-1:0] value);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_wdata <= value;
        @(posedge clk);
    endtask

    task automatic write_markers(input byte_t sm, input byte_t em, input byte_t xm,
                                 input byte_t ss, input byte_t es, input byte_t xs);
        write_register(REG_START_MARKER, LEN_W'(sm));
        write_register(REG_END_MARKER, LEN_W'(em));
        write_register(REG_ESCAPE_MARKER, LEN_W'(xm));
        write_register(REG_START_SUBSTITUTE, LEN_W'(ss));
        write_register(REG_END_SUBSTITUTE, LEN_W'(es));
        write_register(REG_ESCAPE_SUBSTITUTE, LEN_W'(xs));
        cur_start  = sm;
        cur_end    = em;
        cur_escape = xm;
    endtask

    // Payload bytes lean toward the markers so that stuffing happens often.
    function automatic byte_t payload_byte();
        case ($urandom_range(9))
            0: return cur_start;
            1: return cur_end;
            2: return cur_escape;
            default: return byte_t'($urandom_range(255));
        endcase
    endfunction

    // One to three frames sharing one length; some are cut short, overrun or preceded by noise.
    task automatic random_batch();
        logic [LEN_W-1:0] len;
        int               pick;
        int               style;
        int               count;
        pick = $urandom_range(99);
        if (pick < 60)
            len = LEN_W'($urandom_range(6, 1));
        else if (pick < 75)
            len = '0;
        else if (pick < 92)
            len = LEN_W'($urandom_range(20, 7));
        else
            len = {cur_start, cur_escape};
        settle();
        write_register(REG_FRAME_LENGTH, len);
        cfg_we <= 1'b0;
        repeat ($urandom_range(3, 1))
        begin
            style = $urandom_range(99);
            if (style < 8)
                send_command(CMD_DATA, payload_byte());
            send_command(CMD_START, byte_t'($urandom_range(255)));
            count = (len > 24) ? $urandom_range(8, 1) : int'(len);
            if (style >= 8 && style < 18 && count > 0)
                count = $urandom_range(count - 1, 0);
            else if (style >= 18 && style < 28)
                count += $urandom_range(2, 1);
            repeat (count) send_command(CMD_DATA, payload_byte());
        end
    endtask

    initial
    begin
        int    phase_end;
        byte_t shared_marker;

        rst_n           = 1'b0;
        cfg_we          = 1'b0;
        cfg_index       = REG_FRAME_LENGTH;
        cfg_wdata       = '0;
        in_ch.valid     = 1'b0;
        in_ch.command   = CMD_START;
        in_ch.data_byte = '0;
        send_idle_pct   = 0;
        recv_stall_pct  = 0;
        hold_requests   = 0;
        items_sent      = 0;
        cur_start       = RST_START_MARKER;
        cur_end         = RST_END_MARKER;
        cur_escape      = RST_ESCAPE_MARKER;

        repeat (RESET_CYCLES) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Payload before any frame is refused; the reset length gives an empty frame.
        send_command(CMD_DATA, 8'hFF);
        send_command(CMD_START, 8'hFF);
        send_command(CMD_DATA, 8'h00);

        // A short frame carrying each marker, then one byte too many.
        settle();
        write_register(REG_FRAME_LENGTH, 16'd3);
        cfg_we <= 1'b0;
        send_command(CMD_START, 8'h00);
        send_command(CMD_DATA, RST_START_MARKER);
        send_command(CMD_DATA, RST_END_MARKER);
        send_command(CMD_DATA, RST_ESCAPE_MARKER);
        send_command(CMD_DATA, 8'h55);

        // Both length bytes collide with markers and must be stuffed.
        settle();
        write_register(REG_FRAME_LENGTH, 16'h7E7D);
        cfg_we <= 1'b0;
        send_command(CMD_START, 8'h00);
        send_command(CMD_DATA, 8'h00);
        send_command(CMD_DATA, 8'hFF);

        // A new length written mid-frame only affects the next frame.
        settle();
        write_register(REG_FRAME_LENGTH, 16'd2);
        cfg_we <= 1'b0;
        send_command(CMD_DATA, 8'h12);
        send_command(CMD_START, 8'h00);
        send_command(CMD_DATA, RST_END_MARKER);
        send_command(CMD_DATA, 8'h80);

        // Longest length; this frame is abandoned by the next start.
        settle();
        write_register(REG_FRAME_LENGTH, 16'hFFFF);
        cfg_we <= 1'b0;
        send_command(CMD_START, 8'h00);
        send_command(CMD_DATA, 8'hA5);

        // All markers equal: the start substitute wins, and an empty frame is six bytes.
        settle();
        write_markers(8'h00, 8'h00, 8'h00, 8'h11, 8'h22, 8'h33);
        write_register(REG_FRAME_LENGTH, 16'd0);
        cfg_we <= 1'b0;
        send_command(CMD_START, 8'h00);
        settle();
        write_register(REG_FRAME_LENGTH, 16'd1);
        cfg_we <= 1'b0;
        send_command(CMD_START, 8'h00);
        send_command(CMD_DATA, 8'h00);

        // Markers at the top of the byte range, with start and escape shared.
        settle();
        write_markers(8'hFF, 8'hFE, 8'hFF, 8'h00, 8'hFF, 8'h7F);
        write_register(REG_FRAME_LENGTH, 16'hFEFF);
        cfg_we <= 1'b0;
        send_command(CMD_START, 8'h00);
        send_command(CMD_DATA, 8'hFE);
        send_command(CMD_DATA, 8'hFF);
        send_command(CMD_DATA, 8'h01);

        // Random phases, each with its own markers and idling pattern.
        for (int p = 0; p < 4; p++)
        begin
            settle();
            case (p)
                0:
                begin
                    write_markers(byte_t'($urandom_range(255)), byte_t'($urandom_range(255)),
                                  byte_t'($urandom_range(255)), byte_t'($urandom_range(255)),
                                  byte_t'($urandom_range(255)), byte_t'($urandom_range(255)));
                    send_idle_pct = 0;
                    recv_stall_pct <= 0;
                end
                1:
                begin
                    write_markers(8'hFF, 8'h00, 8'h80, 8'h00, 8'hFF, 8'h7F);
                    send_idle_pct = 50;
                    recv_stall_pct <= 0;
                end
                2:
                begin
                    shared_marker = byte_t'($urandom_range(255));
                    write_markers(shared_marker, shared_marker, byte_t'($urandom_range(255)),
                                  byte_t'($urandom_range(255)), byte_t'($urandom_range(255)),
                                  byte_t'($urandom_range(255)));
                    send_idle_pct = 0;
                    recv_stall_pct <= 50;
                end
                default:
                begin
                    write_markers(RST_START_MARKER, RST_END_MARKER, RST_ESCAPE_MARKER,
                                  RST_START_SUBSTITUTE, RST_END_SUBSTITUTE,
                                  RST_ESCAPE_SUBSTITUTE);
                    send_idle_pct = 14;
                    recv_stall_pct <= 14;
                end
            endcase
            cfg_we <= 1'b0;

            // Back-pressure: the receiver holds off while a long frame keeps coming.
            if (p == 0)
            begin
                settle();
                write_register(REG_FRAME_LENGTH, 16'd40);
                cfg_we <= 1'b0;
                hold_requests <= hold_requests + 1;
                send_command(CMD_START, 8'h00);
                repeat (40) send_command(CMD_DATA, payload_byte());
            end

            phase_end = items_sent + PHASE_ITEMS;
            while (items_sent < phase_end)
            begin
                random_batch();
            end
        end

        // Let the last bytes drain and watch for anything extra.
        settle();
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (mismatch_count == 0)
        begin
            $display("Regression PASS");
        end
        else
        begin
            $display("Regression FAIL");
        end
        $finish;
    end

endmodule
